// ----- design/mtt_pkg.sv -----
// Package for the map text tokenizer: result kinds, character codes,
// default sizes and the result group that travels from lexer to output stage.
// Used by every module of the block; depends on nothing.
package mtt_pkg;

    localparam int TOKEN_LIMIT_DEF = 4096;
    localparam int LINE_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LINE_NUM_W      = 24;
    localparam int RES_MAX         = 3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_GAP_MAX = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_X       = 8'h58;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_END   = 3'd1,
        KIND_TX    = 3'd2,
        KIND_LINE  = 3'd3,
        KIND_LARGE = 3'd4,
        KIND_DONE  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } res_t;

    typedef struct packed {
        logic [1:0]                count;
        res_t [RES_MAX-1:0]        res;
        logic [LINE_NUM_W-1:0]     line;
    } grp_t;

endpackage

// ----- design/mtt_front.sv -----
// Lexer front end: takes one text beat per cycle while push_ready is high,
// updates lexer state, builds the beat's result group. Depends on mtt_pkg.
module mtt_front
    import mtt_pkg::*;
#(
    parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_mark,
    input  logic       newline_ok,
    output logic       push_valid,
    input  logic       push_ready,
    output grp_t       push_data
);

    localparam int LEN_W = $clog2(TOKEN_LIMIT);

    typedef enum logic [2:0] {
        MODE_GAP,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_WORD,
        MODE_QUOTED,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0] {
        OFF_START,
        OFF_GOT_T,
        OFF_GOT_TX,
        OFF_REST
    } off_t;

    mode_t                mode_reg, mode_next;
    off_t                 off_reg, off_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 halt_reg, halt_next;

    grp_t                 grp;
    logic                 in_fire;
    logic                 run_gap;
    logic                 run_word;
    logic                 run_push;
    logic [LEN_W-1:0]     push_len;
    logic [LEN_W:0]       len_inc;
    logic                 is_gap;

    function automatic grp_t add_res(grp_t g, kind_t k, logic [7:0] v);
        grp_t r;
        r                  = g;
        r.res[g.count].kind  = k;
        r.res[g.count].value = v;
        r.count            = g.count + 2'd1;
        return r;
    endfunction

    assign in_ready   = push_ready;
    assign in_fire    = in_valid && in_ready;
    assign is_gap     = (text_byte <= CH_GAP_MAX);
    assign len_inc    = {1'b0, push_len} + (LEN_W+1)'(1);
    assign push_valid = in_fire && (grp.count != 2'd0);
    assign push_data  = grp;

    always_comb
    begin
        grp        = '0;
        grp.line   = LINE_NUM_W'(line_reg);
        mode_next  = mode_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        halt_next  = halt_reg;
        run_gap    = 1'b0;
        run_word   = 1'b0;
        run_push   = 1'b0;
        push_len   = len_reg;

        if (in_fire && !halt_reg)
        begin
            if (end_mark)
            begin
                case (mode_reg)
                    MODE_SLASH:
                    begin
                        grp      = add_res(grp, KIND_BYTE, CH_SLASH);
                        grp      = add_res(grp, KIND_END, 8'd0);
                        len_next = LEN_W'(1);
                    end
                    MODE_WORD, MODE_QUOTED:
                    begin
                        grp = add_res(grp, KIND_END, 8'd0);
                    end
                    default:
                    begin
                    end
                endcase
                grp       = add_res(grp, KIND_DONE, 8'd0);
                mode_next = MODE_DONE;
            end
            else
            begin
                case (mode_reg)
                    MODE_GAP:
                    begin
                        run_gap = 1'b1;
                    end
                    MODE_SLASH:
                    begin
                        if (text_byte == CH_SLASH)
                        begin
                            if (!newline_ok)
                            begin
                                grp       = add_res(grp, KIND_LINE, 8'd0);
                                halt_next = 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_COMMENT;
                                off_next  = OFF_START;
                            end
                        end
                        else
                        begin
                            grp       = add_res(grp, KIND_BYTE, CH_SLASH);
                            mode_next = MODE_WORD;
                            push_len  = LEN_W'(1);
                            len_next  = LEN_W'(1);
                            run_word  = 1'b1;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        case (off_reg)
                            OFF_START: off_next = (text_byte == CH_T) ? OFF_GOT_T : OFF_REST;
                            OFF_GOT_T: off_next = (text_byte == CH_X) ? OFF_GOT_TX : OFF_REST;
                            OFF_GOT_TX:
                            begin
                                grp      = add_res(grp, KIND_TX, text_byte);
                                off_next = OFF_REST;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (text_byte == CH_NEWLINE)
                        begin
                            if (line_reg != '1)
                            begin
                                line_next = line_reg + LINE_BITS'(1);
                            end
                            mode_next = MODE_GAP;
                            off_next  = OFF_START;
                        end
                    end
                    MODE_WORD:
                    begin
                        run_word = 1'b1;
                    end
                    MODE_QUOTED:
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            grp       = add_res(grp, KIND_END, 8'd0);
                            mode_next = MODE_GAP;
                        end
                        else
                        begin
                            run_push = 1'b1;
                        end
                    end
                    default:
                    begin
                        grp       = add_res(grp, KIND_DONE, 8'd0);
                        mode_next = MODE_DONE;
                    end
                endcase

                if (run_word)
                begin
                    if (is_gap || (text_byte == CH_SEMI))
                    begin
                        grp       = add_res(grp, KIND_END, 8'd0);
                        mode_next = MODE_GAP;
                        run_gap   = 1'b1;
                    end
                    else
                    begin
                        run_push = 1'b1;
                    end
                end

                if (run_gap)
                begin
                    if (is_gap)
                    begin
                        if (text_byte == CH_NEWLINE)
                        begin
                            if (!newline_ok)
                            begin
                                grp       = add_res(grp, KIND_LINE, 8'd0);
                                halt_next = 1'b1;
                            end
                            else if (line_reg != '1)
                            begin
                                line_next = line_reg + LINE_BITS'(1);
                            end
                        end
                        mode_next = MODE_GAP;
                    end
                    else if (text_byte inside {CH_SEMI, CH_HASH})
                    begin
                        if (!newline_ok)
                        begin
                            grp       = add_res(grp, KIND_LINE, 8'd0);
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_COMMENT;
                            off_next  = OFF_START;
                        end
                    end
                    else if (text_byte == CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTED;
                        len_next  = '0;
                    end
                    else
                    begin
                        mode_next = MODE_WORD;
                        push_len  = '0;
                        run_push  = 1'b1;
                    end
                end

                if (run_push)
                begin
                    grp = add_res(grp, KIND_BYTE, text_byte);
                    if (len_inc >= (LEN_W+1)'(TOKEN_LIMIT))
                    begin
                        grp       = add_res(grp, KIND_LARGE, 8'd0);
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        len_next = LEN_W'(len_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_GAP;
            off_reg  <= OFF_START;
            len_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            halt_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            off_reg  <= off_next;
            len_reg  <= len_next;
            line_reg <= line_next;
            halt_reg <= halt_next;
        end
    end

endmodule

// ----- design/mtt_queue.sv -----
// Short queue of result groups between the lexer and the output stage.
// Depends on mtt_pkg for the group type.
module mtt_queue
    import mtt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  grp_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output grp_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    grp_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/mtt_back.sv -----
// Output stage: holds one result group and, when out_ready is set, hands
// out its results one per cycle, marking the last. Depends on mtt_pkg.
module mtt_back
    import mtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  grp_t                  pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            kind,
    output logic [7:0]            value,
    output logic [LINE_NUM_W-1:0] line_number,
    output logic                  last
);

    grp_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic       out_fire;

    assign out_valid   = cur_valid_reg;
    assign out_fire    = out_valid && out_ready;
    assign last        = (idx_reg == (cur_reg.count - 2'd1));
    assign kind        = cur_reg.res[idx_reg].kind;
    assign value       = cur_reg.res[idx_reg].value;
    assign line_number = cur_reg.line;
    assign pop_ready   = !cur_valid_reg || (out_fire && last);

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            cur_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (pop_valid && pop_ready)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_fire && last)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ----- design/map_text_tokenizer_unit.sv -----
// Top level of the map text tokenizer: lexer front end, group queue and
// output stage. Depends on mtt_pkg, mtt_front, mtt_queue and mtt_back.
//
//   Channel   Handshake               Beat contents
//   in        in_valid / in_ready     text_byte, end_mark, newline_ok
//   out       out_valid / out_ready   kind, value, line_number, last
//
// The lexer takes one text beat per cycle while the group queue has room, so
// beats may follow back to back.
// Each beat causes zero to three results; the output stage sends one result per
// cycle while out_ready is high, so sustained input rate is one beat per cycle
// when beats yield at most one result, and the output port bounds it otherwise.
// Reset starts the lexer in the gap mode on line one; no clearing pass is needed.
// A stalled output fills the queue, and only then is in_ready dropped.
module map_text_tokenizer_unit
    import mtt_pkg::*;
#(
    parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            text_byte,
    input  logic                  end_mark,
    input  logic                  newline_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            kind,
    output logic [7:0]            value,
    output logic [LINE_NUM_W-1:0] line_number,
    output logic                  last
);

    logic push_valid;
    logic push_ready;
    grp_t push_data;
    logic pop_valid;
    logic pop_ready;
    grp_t pop_data;

    mtt_front #(
        .TOKEN_LIMIT (TOKEN_LIMIT),
        .LINE_BITS   (LINE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .end_mark   (end_mark),
        .newline_ok (newline_ok),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mtt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mtt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value),
        .line_number (line_number),
        .last        (last)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for map_text_tokenizer_unit: map text streams in,
// tokens, command bytes and line errors stream out and are checked in order.
// Depends on mtt_pkg and the map_text_tokenizer_unit RTL.
`timescale 1ns / 1ps

module tb;
    import mtt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 20;

    typedef enum logic [2:0] {
        MODE_GAP,
        MODE_SLASH,
        MODE_CMT,
        MODE_WORD,
        MODE_QUOTED,
        MODE_DONE
    } lex_mode_t;

    typedef enum logic [1:0] {
        CMT_AT_T,
        CMT_AT_X,
        CMT_AT_CMD,
        CMT_PLAIN
    } cmt_pos_t;

    typedef enum int {
        END_IN_WORD,
        END_AFTER_SLASH,
        END_IN_QUOTE,
        END_IN_COMMENT,
        BREAK_GAP_LINE,
        BREAK_COMMENT,
        BREAK_SLASH_PAIR,
        OVERSIZE_TOKEN
    } finale_t;

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            value;
        logic [LINE_NUM_W-1:0] line;
        logic                  last;
    } text_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            text_byte = 8'h00;
    logic                  end_mark = 1'b0;
    logic                  newline_ok = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            kind;
    logic [7:0]            value;
    logic [LINE_NUM_W-1:0] line_number;
    logic                  last;

    lex_mode_t               lx_mode = MODE_GAP;
    cmt_pos_t                cmt_pos = CMT_AT_T;
    int                      tok_len = 0;
    logic [LINE_BITS_DEF-1:0] line_cnt = LINE_BITS_DEF'(1);
    bit                      lx_halt = 1'b0;
    text_result_t            step_res [RES_MAX];
    int                      step_cnt;

    text_result_t due_results [$];
    logic [7:0]   text_q [$];
    int           beats_sent = 0;
    int           beats_seen = 0;
    int           err_cnt = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    map_text_tokenizer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_mark    (end_mark),
        .newline_ok  (newline_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value),
        .line_number (line_number),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void add_char(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function void note_result(kind_t k, logic [7:0] v);
        if (step_cnt < RES_MAX)
        begin
            step_res[step_cnt] = '{kind: k, value: v, line: line_cnt[LINE_NUM_W-1:0],
                                   last: 1'b0};
            step_cnt++;
        end
    endfunction

    function void count_line();
        if (line_cnt != '1)
            line_cnt++;
    endfunction

    function void abort(kind_t k);
        note_result(k, 8'h00);
        lx_halt = 1'b1;
    endfunction

    function void token_byte(logic [7:0] b);
        note_result(KIND_BYTE, b);
        tok_len++;
        if (tok_len >= TOKEN_LIMIT_DEF)
            abort(KIND_LARGE);
    endfunction

    function void gap_char(logic [7:0] b, logic ok);
        if (b <= CH_GAP_MAX)
        begin
            if (b == CH_NEWLINE)
            begin
                if (!ok)
                    abort(KIND_LINE);
                else
                    count_line();
            end
            lx_mode = MODE_GAP;
        end
        else if (b == CH_SEMI || b == CH_HASH)
        begin
            if (!ok)
                abort(KIND_LINE);
            else
            begin
                lx_mode = MODE_CMT;
                cmt_pos = CMT_AT_T;
            end
        end
        else if (b == CH_SLASH)
            lx_mode = MODE_SLASH;
        else if (b == CH_QUOTE)
        begin
            lx_mode = MODE_QUOTED;
            tok_len = 0;
        end
        else
        begin
            lx_mode = MODE_WORD;
            tok_len = 0;
            token_byte(b);
        end
    endfunction

    function void word_char(logic [7:0] b, logic ok);
        if (b <= CH_GAP_MAX || b == CH_SEMI)
        begin
            note_result(KIND_END, 8'h00);
            lx_mode = MODE_GAP;
            gap_char(b, ok);
        end
        else
            token_byte(b);
    endfunction

    function void comment_char(logic [7:0] b);
        case (cmt_pos)
            CMT_AT_T: cmt_pos = (b == CH_T) ? CMT_AT_X : CMT_PLAIN;
            CMT_AT_X: cmt_pos = (b == CH_X) ? CMT_AT_CMD : CMT_PLAIN;
            CMT_AT_CMD:
            begin
                note_result(KIND_TX, b);
                cmt_pos = CMT_PLAIN;
            end
            default: ;
        endcase
        if (b == CH_NEWLINE)
        begin
            count_line();
            lx_mode = MODE_GAP;
            cmt_pos = CMT_AT_T;
        end
    endfunction

    function void lex_beat(logic [7:0] b, logic e, logic ok);
        step_cnt = 0;
        if (lx_halt)
            return;
        if (e)
        begin
            if (lx_mode == MODE_SLASH)
            begin
                tok_len = 0;
                token_byte(CH_SLASH);
                if (!lx_halt)
                    note_result(KIND_END, 8'h00);
            end
            else if (lx_mode == MODE_WORD || lx_mode == MODE_QUOTED)
                note_result(KIND_END, 8'h00);
            if (!lx_halt)
            begin
                note_result(KIND_DONE, 8'h00);
                lx_mode = MODE_DONE;
            end
        end
        else
        begin
            case (lx_mode)
                MODE_GAP: gap_char(b, ok);
                MODE_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        if (!ok)
                            abort(KIND_LINE);
                        else
                        begin
                            lx_mode = MODE_CMT;
                            cmt_pos = CMT_AT_T;
                        end
                    end
                    else
                    begin
                        lx_mode = MODE_WORD;
                        tok_len = 0;
                        token_byte(CH_SLASH);
                        if (!lx_halt)
                            word_char(b, ok);
                    end
                end
                MODE_CMT: comment_char(b);
                MODE_WORD: word_char(b, ok);
                MODE_QUOTED:
                begin
                    if (b == CH_QUOTE)
                    begin
                        note_result(KIND_END, 8'h00);
                        lx_mode = MODE_GAP;
                    end
                    else
                        token_byte(b);
                end
                default:
                begin
                    note_result(KIND_DONE, 8'h00);
                    lx_mode = MODE_DONE;
                end
            endcase
        end
        if (step_cnt > 0)
            step_res[step_cnt-1].last = 1'b1;
    endfunction

    function bit halts_on(logic [7:0] b, logic e, logic ok);
        lex_mode_t                m;
        cmt_pos_t                 c;
        int                       t;
        logic [LINE_BITS_DEF-1:0] l;
        bit                       h;
        bit                       hit;
        m = lx_mode;
        c = cmt_pos;
        t = tok_len;
        l = line_cnt;
        h = lx_halt;
        lex_beat(b, e, ok);
        hit = lx_halt && !h;
        lx_mode = m;
        cmt_pos = c;
        tok_len = t;
        line_cnt = l;
        lx_halt = h;
        return hit;
    endfunction

    function logic [7:0] pick_word_start();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 255));
        while (b == CH_SEMI || b == CH_HASH || b == CH_SLASH || b == CH_QUOTE);
        return b;
    endfunction

    function logic [7:0] pick_word_body();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 255));
        while (b == CH_SEMI);
        return b;
    endfunction

    function void make_line();
        int         parts;
        int         r;
        logic [7:0] b;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 8))
                add_char(8'($urandom_range(255)));
            return;
        end
        parts = $urandom_range(1, 4);
        for (int i = 0; i < parts; i++)
        begin
            r = $urandom_range(9);
            if (r < 6)
            begin
                if ($urandom_range(3) == 0)
                    add_char(CH_SLASH);
                else
                    add_char(pick_word_start());
                repeat ($urandom_range(0, 5))
                    add_char(pick_word_body());
            end
            else
            begin
                add_char(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == CH_QUOTE);
                    if ($urandom_range(3) == 0)
                        b = CH_NEWLINE;
                    add_char(b);
                end
                add_char(CH_QUOTE);
            end
            if ($urandom_range(99) < 85)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    do
                        b = 8'($urandom_range(32));
                    while (b == CH_NEWLINE);
                    add_char(b);
                end
            end
        end
        if ($urandom_range(1))
        begin
            r = $urandom_range(2);
            if (r == 0)
                add_char(CH_SEMI);
            else if (r == 1)
                add_char(CH_HASH);
            else
            begin
                add_char(CH_SLASH);
                add_char(CH_SLASH);
            end
            if ($urandom_range(1))
            begin
                add_char(CH_T);
                add_char(CH_X);
                add_char($urandom_range(7) == 0 ? CH_NEWLINE : 8'($urandom_range(255)));
            end
            repeat ($urandom_range(0, 4))
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_NEWLINE);
                add_char(b);
            end
        end
        add_char(CH_NEWLINE);
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic e, input logic ok, input bit guard);
        logic ok_q;
        ok_q = ok;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (guard && halts_on(b, e, ok_q))
            ok_q = 1'b1;
        in_valid <= 1'b1;
        text_byte <= b;
        end_mark <= e;
        newline_ok <= ok_q;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        beats_sent++;
        wait (beats_seen == beats_sent);
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_beat(text_q.pop_front(), 1'b0, $urandom_range(99) < 80, 1'b1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] seq [25];
        seq = '{8'hFF, 8'h80, CH_SEMI, CH_T, CH_X, "q", CH_NEWLINE,
                CH_QUOTE, "a", CH_NEWLINE, CH_QUOTE, " ",
                CH_SLASH, "z", CH_SLASH, " ", CH_SLASH, CH_SLASH, CH_T, CH_X, CH_NEWLINE,
                8'h00, CH_NEWLINE, CH_HASH, CH_NEWLINE};
        foreach (seq[i])
            send_beat(seq[i], 1'b0, 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic test_random_text(input int idle, input int stall, input int beats);
        int stop;
        send_idle_pct = idle;
        stall_pct = stall;
        stop = beats_sent + beats;
        while (beats_sent < stop)
        begin
            make_line();
            send_text();
        end
    endtask

    task automatic test_backpressure();
        int stop;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left <= HOLD_CYCLES;
        stop = beats_sent + 30;
        while (beats_sent < stop)
        begin
            make_line();
            send_text();
        end
        drain_results();
        make_line();
        send_text();
    endtask

    task automatic test_terminal();
        finale_t    pick;
        logic [7:0] b;
        pick = finale_t'($urandom_range(7));
        send_idle_pct = 23;
        stall_pct = 23;
        while (lx_mode != MODE_GAP)
        begin
            if (lx_mode == MODE_QUOTED)
                send_beat(CH_QUOTE, 1'b0, 1'b1, 1'b1);
            else if (lx_mode == MODE_CMT)
                send_beat(CH_NEWLINE, 1'b0, 1'b1, 1'b1);
            else
                send_beat(" ", 1'b0, 1'b1, 1'b1);
        end
        case (pick)
            END_IN_WORD: add_char(pick_word_start());
            END_AFTER_SLASH: add_char(CH_SLASH);
            END_IN_QUOTE:
            begin
                add_char(CH_QUOTE);
                add_char("q");
            end
            END_IN_COMMENT:
            begin
                add_char(CH_HASH);
                add_char("x");
            end
            OVERSIZE_TOKEN:
            begin
                if ($urandom_range(1))
                begin
                    add_char(CH_QUOTE);
                    repeat (TOKEN_LIMIT_DEF)
                    begin
                        do
                            b = 8'($urandom_range(255));
                        while (b == CH_QUOTE);
                        add_char(b);
                    end
                end
                else
                begin
                    add_char(pick_word_start());
                    repeat (TOKEN_LIMIT_DEF - 1)
                        add_char(pick_word_body());
                end
            end
            default: ;
        endcase
        send_text();
        case (pick)
            END_IN_WORD, END_AFTER_SLASH, END_IN_QUOTE, END_IN_COMMENT:
                send_beat(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), 1'b0);
            BREAK_GAP_LINE: send_beat(CH_NEWLINE, 1'b0, 1'b0, 1'b0);
            BREAK_COMMENT: send_beat($urandom_range(1) ? CH_SEMI : CH_HASH, 1'b0, 1'b0, 1'b0);
            BREAK_SLASH_PAIR:
            begin
                send_beat(CH_SLASH, 1'b0, 1'($urandom_range(1)), 1'b0);
                send_beat(CH_SLASH, 1'b0, 1'b0, 1'b0);
            end
            default: ;
        endcase
        repeat (4)
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        text_result_t want;
        if (rst_n && in_valid && in_ready === 1'b1)
        begin
            lex_beat(text_byte, end_mark, newline_ok);
            for (int i = 0; i < step_cnt; i++)
                due_results.insert(due_results.size(), step_res[i]);
            beats_seen++;
        end
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("Unexpected result at %0t: kind %0d value %02h line %0d last %0b",
                             $time, kind, value, line_number, last);
            end
            else
            begin
                want = due_results.pop_front();
                if (kind !== want.kind || value !== want.value ||
                    line_number !== want.line || last !== want.last)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"Mismatch at %0t: expected kind %0d value %02h line %0d ",
                                  "last %0b, got kind %0d value %02h line %0d last %0b"},
                                 $time, want.kind, want.value, want.line, want.last,
                                 kind, value, line_number, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text(0, 0, 40);
        test_random_text(48, 0, 40);
        test_random_text(0, 48, 40);
        test_random_text(23, 23, 40);
        test_backpressure();
        test_terminal();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- map_text_tokenizer_unit.f -----
design/mtt_pkg.sv
design/mtt_front.sv
design/mtt_queue.sv
design/mtt_back.sv
design/map_text_tokenizer_unit.sv
verif/tb.sv
